FILE: hw/rtl/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern search unit.
package wbps_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_BYTES   = 16;
   localparam int OFFSET_W    = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_CARE_MASK      = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] care_mask;
      logic [4:0]  pattern_length;
   } wbps_cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } wbps_req_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } wbps_rsp_type;

   localparam wbps_cfg_type CFG_RESET = '{
      pattern_low:    64'h0,
      pattern_high:   64'h0,
      care_mask:      16'hFFFF,
      pattern_length: 5'd16
   };

endpackage

FILE: hw/rtl/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit.
// One region byte is accepted per cycle, sustained, while the result side
// takes its beats; a result passes through the input register, then the
// result register, and a byte waits in the input register while the result
// side stalls. The rate is set by the window compare, a combinational
// parallel comparator over PATTERN_MAX positions between those two registers.
// A region gives at most one result: the first match offset, or not found
// when the last byte passes without a match.
module wildcard_byte_pattern_search_unit #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wbps_pkg::wbps_req_type              req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wbps_pkg::wbps_rsp_type              rsp_beat
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int OW    = wbps_pkg::OFFSET_W;

   wbps_pkg::wbps_cfg_type        cfg_ff, cfg_in;
   logic                          s1_valid_ff, s1_valid_in;
   wbps_pkg::wbps_req_type        s1_beat_ff;
   logic [PATTERN_MAX-1:0][7:0]   window_ff, window_in, win_next;
   logic [OW-1:0]                 seen_ff, seen_in, seen_next;
   logic                          reported_ff, reported_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   wbps_pkg::wbps_rsp_type        rsp_beat_ff, rsp_beat_in;
   logic                          s1_fire, match, emit, hit;
   logic [LEN_W-1:0]              eff_len;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            wbps_pkg::CSR_PATTERN_LOW:    cfg_in.pattern_low    = csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH:   cfg_in.pattern_high   = csr_wdata;
            wbps_pkg::CSR_CARE_MASK:      cfg_in.care_mask      = csr_wdata[15:0];
            wbps_pkg::CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[4:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      win_next[0] = s1_beat_ff.data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_next[i] = window_ff[i-1];
      end
   end

   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + OW'(1);

   wbps_window_match #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_match (
      .window (win_next),
      .cfg    (cfg_ff),
      .eff_len(eff_len),
      .hit    (hit)
   );

   assign match = !reported_ff && (seen_next >= OW'(eff_len)) && hit;
   assign emit  = match || (s1_beat_ff.last_byte && !reported_ff);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      window_in    = window_ff;
      seen_in      = seen_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;

      if (req_ready) begin
         s1_valid_in = req_valid;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         if (s1_beat_ff.last_byte) begin
            window_in   = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            window_in   = win_next;
            seen_in     = seen_next;
            reported_in = reported_ff || match;
         end
         if (emit) begin
            rsp_valid_in             = 1'b1;
            rsp_beat_in.found        = match;
            rsp_beat_in.match_offset = match ? seen_next - OW'(eff_len) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= wbps_pkg::CFG_RESET;
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_beat_ff <= req_beat;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_beat_ff.found |-> rsp_beat_ff.match_offset == '0)
      else $error("not-found beat carries a nonzero offset");

   a_reported_has_bytes: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> seen_ff != '0)
      else $error("match flagged in an empty region");

   a_match_sets_flag: assert property (@(posedge clock) disable iff (reset)
      s1_fire && match && !s1_beat_ff.last_byte |=> reported_ff)
      else $error("match did not mark the region as reported");

   a_no_second_match: assert property (@(posedge clock) disable iff (reset)
      s1_fire && reported_ff |-> !match)
      else $error("second match in one region");

endmodule

FILE: hw/rtl/wbps_window_match.sv
// Parallel wildcard compare of the byte window against the configured pattern.
module wbps_window_match #(
   parameter int PATTERN_MAX = 16,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1),
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  logic [PATTERN_MAX-1:0][7:0] window,
   input  wbps_pkg::wbps_cfg_type      cfg,
   output logic [LEN_W-1:0]            eff_len,
   output logic                        hit
);

   logic [127:0]            pattern_full;
   logic [PATTERN_MAX-1:0]  pos_ok;

   assign pattern_full = {cfg.pattern_high, cfg.pattern_low};

   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         eff_len = LEN_W'(1);
      end else if (32'(cfg.pattern_length) > 32'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = LEN_W'(cfg.pattern_length);
      end
   end

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pos
      logic [LEN_W-1:0] idx;
      logic             in_use;
      assign idx    = eff_len - LEN_W'(k) - LEN_W'(1);
      assign in_use = LEN_W'(k) < eff_len;
      if (k < wbps_pkg::PAT_BYTES) begin : g_cfg
         assign pos_ok[k] = !in_use || !cfg.care_mask[k] ||
                            (window[idx[IDX_W-1:0]] == pattern_full[8*k +: 8]);
      end else begin : g_wild
         assign pos_ok[k] = 1'b1;
      end
   end

   assign hit = &pos_ok;

endmodule

FILE: verif/tb_wildcard_byte_pattern_search_unit.sv
// Self-checking testbench for the wildcard byte pattern search unit: directed and random regions.
module tb_wildcard_byte_pattern_search_unit;
   import wbps_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_BYTES   = 400;
   localparam int PHASE_BYTES    = 60;
   localparam int MAX_REPORTS    = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   wbps_req_type           req_beat  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   wbps_rsp_type           rsp_beat;

   wbps_cfg_type cfg_shadow = CFG_RESET;
   logic [7:0]   window [PAT_BYTES];
   logic [31:0]  bytes_seen;
   logic         match_reported;
   wbps_rsp_type pending_outcomes [$];
   int           mismatch_count = 0;
   int           bytes_sent     = 0;
   int           gap_pct        = 0;
   int           stall_pct      = 0;

   wildcard_byte_pattern_search_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_length();
      int n;
      n = int'(cfg_shadow.pattern_length);
      if (n < 1) n = 1;
      if (n > PAT_BYTES) n = PAT_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(int k);
      if (k < 8) begin
         return cfg_shadow.pattern_low[8*k +: 8];
      end else begin
         return cfg_shadow.pattern_high[8*(k-8) +: 8];
      end
   endfunction

   function automatic void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      bytes_seen     = '0;
      match_reported = 1'b0;
   endfunction

   function automatic void advance_window(wbps_req_type beat);
      int           len;
      logic         hit;
      wbps_rsp_type outcome;
      len = eff_length();
      for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = beat.data_byte;
      if (bytes_seen != '1) bytes_seen++;
      if (!match_reported && bytes_seen >= len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (cfg_shadow.care_mask[k] && window[len-1-k] != pattern_byte(k)) hit = 1'b0;
         end
         if (hit) begin
            match_reported       = 1'b1;
            outcome.found        = 1'b1;
            outcome.match_offset = bytes_seen - len;
            pending_outcomes.push_back(outcome);
         end
      end
      if (beat.last_byte) begin
         if (!match_reported) begin
            outcome = '0;
            pending_outcomes.push_back(outcome);
         end
         clear_region();
      end
   endfunction

   function automatic void flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   task automatic settle();
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_PATTERN_LOW:    cfg_shadow.pattern_low    = value;
         CSR_PATTERN_HIGH:   cfg_shadow.pattern_high   = value;
         CSR_CARE_MASK:      cfg_shadow.care_mask      = value[15:0];
         CSR_PATTERN_LENGTH: cfg_shadow.pattern_length = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [15:0] care,
                              logic [4:0] length);
      settle();
      write_csr(CSR_PATTERN_LOW, lo);
      write_csr(CSR_PATTERN_HIGH, hi);
      write_csr(CSR_CARE_MASK, {48'h0, care});
      write_csr(CSR_PATTERN_LENGTH, {59'h0, length});
   endtask

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_byte(logic [7:0] data, logic last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < gap_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 2);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_beat.data_byte = data;
      req_beat.last_byte = last;
      req_valid          = 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_window(req_beat);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_region();
      int         len;
      int         region_len;
      int         plant_at;
      logic [7:0] data;
      len = eff_length();
      case ($urandom_range(9))
         0:       region_len = $urandom_range(1, len);
         1:       region_len = $urandom_range(len, 48);
         default: region_len = $urandom_range(len, len + 8);
      endcase
      plant_at = -1;
      if (region_len >= len && $urandom_range(3) != 0) begin
         plant_at = $urandom_range(0, region_len - len);
      end
      for (int i = 0; i < region_len; i++) begin
         if (plant_at >= 0 && i >= plant_at && i < plant_at + len &&
             cfg_shadow.care_mask[i - plant_at]) begin
            data = pattern_byte(i - plant_at);
         end else if ($urandom_range(2) == 0) begin
            data = 8'($urandom_range(255));
         end else begin
            data = pattern_byte($urandom_range(len - 1));
         end
         send_byte(data, i == region_len - 1);
      end
   endtask

   task automatic test_single_byte_pattern();
      gap_pct   = 30;
      stall_pct = 30;
      set_pattern(64'hFF, 64'h0, 16'hFFFF, 5'd1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // second hit in the region is dropped, no result at region end
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_wildcard_positions();
      set_pattern(64'h0000_0000_5500_00AA, 64'h0, 16'h0009, 5'd4);
      // region shorter than the pattern
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      // match completed by the last byte
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h13, 1'b0);
      send_byte(8'h37, 1'b0);
      send_byte(8'h55, 1'b1);
   endtask

   task automatic test_length_limits();
      set_pattern(64'hAA, '1, 16'hFFFF, 5'd0);
      send_byte(8'hAA, 1'b1);
      set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd31);
      for (int i = 0; i < 16; i++) send_byte((i % 2) ? 8'hFF : 8'h00, i == 15);
   endtask

   task automatic test_random_regions();
      int          phase;
      int          start;
      int          phase_start;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] care;
      logic [4:0]  length;
      phase = 0;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         lo     = {$urandom, $urandom};
         hi     = {$urandom, $urandom};
         care   = 16'($urandom);
         length = 5'($urandom_range(1, 16));
         case (phase % 6)
            0: begin
               lo     = '0;
               hi     = '0;
               care   = '1;
               length = 5'd1;
            end
            1: begin
               lo     = '1;
               hi     = '1;
               care   = '1;
               length = 5'd16;
            end
            2: length = 5'd0;
            3: begin
               length = 5'($urandom_range(17, 31));
               care   = 16'($urandom & $urandom);
            end
            default: ;
         endcase
         gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
         stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 50);
         set_pattern(lo, hi, care, length);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) send_region();
         phase++;
      end
   endtask

   initial begin : rsp_stall
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if ($urandom_range(99) < stall_pct) begin
            rsp_ready = 1'b0;
            hold = ($urandom_range(9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 2);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      wbps_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat found=%0b offset=%0d",
                                    rsp_beat.found, rsp_beat.match_offset));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_beat.found !== want.found) begin
               flag_mismatch($sformatf("found expected %0b actual %0b",
                                       want.found, rsp_beat.found));
            end
            if (rsp_beat.match_offset !== want.match_offset) begin
               flag_mismatch($sformatf("match_offset expected %0d actual %0d",
                                       want.match_offset, rsp_beat.match_offset));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      clear_region();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_byte_pattern();
      test_wildcard_positions();
      test_length_limits();
      test_random_regions();
      settle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: wildcard_byte_pattern_search_unit.f
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_window_match.sv
hw/rtl/wildcard_byte_pattern_search_unit.sv
verif/tb_wildcard_byte_pattern_search_unit.sv
